@@ rtl/core/wcv_pkg.sv @@
package wcv_pkg;

	localparam int unsigned CHANNELS_DEF    = 2;
	localparam int unsigned SAMPLE_BITS_DEF = 16;

	localparam logic [31:0] WANT_RATE_RST = 32'd48000;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [5:0]  MIN_LEN   = 6'd44;
	localparam logic [31:0] FMT_LEN   = 32'd16;
	localparam logic [29:0] COUNT_MAX = 30'h3FFF_FFFF;

	typedef enum logic [2:0] {
		PH_RIFF,
		PH_HDR,
		PH_FMT,
		PH_BODY,
		PH_PAD
	} phase_t;

	// verdict of one file, before the frame division
	typedef struct packed {
		logic        ok;
		logic [31:0] size;
	} verdict_t;

	// byte idx of a four-character tag, first character first
	function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
		tag_byte = tag[{~idx, 3'b000} +: 8];
	endfunction

endpackage

@@ rtl/core/wav_chunk_validator.sv @@
// RIFF WAVE stream checker.
// Input channel: one file byte per item (data_byte), last_byte set on the final
// byte of a file; in_valid/in_ready handshake. One byte can be taken every cycle.
// Output channel: one item per file, out_valid/out_ready, carrying valid_res and
// frame_count (data bytes / frame size, saturated to 30 bits, 0 when invalid).
// Bytes other than the last produce no output item.
// Pipeline: the verdict passes the verdict stage, the reciprocal multiply, then the
// correction into the output register.
// Throughput: one byte per cycle unless stalled; the byte parser is a single state
// update and the frame division is a pipelined multiply by a constant reciprocal.
// Configuration: cfg_we writes cfg_wdata into the expected sample rate; write
// only between files with the pipeline drained.
// Reset: rate returns to 48000 and the parser waits for "RIFF".
// Stall: while a result sits unaccepted in the output register the whole
// pipeline holds and in_ready is low; nothing is dropped.
module wav_chunk_validator #(
	parameter int unsigned CHANNELS    = wcv_pkg::CHANNELS_DEF,
	parameter int unsigned SAMPLE_BITS = wcv_pkg::SAMPLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        valid_res,
	output logic [29:0] frame_count,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	logic              en;
	logic              take;
	logic [31:0]       want_rate_q;
	logic              verdict_vld_s1;
	wcv_pkg::verdict_t verdict_s1;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign take     = in_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_rate_q <= wcv_pkg::WANT_RATE_RST;
		end else if (cfg_we) begin
			want_rate_q <= cfg_wdata;
		end
	end

	wcv_parser #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.en             (en),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.want_rate      (want_rate_q),
		.verdict_vld_s1 (verdict_vld_s1),
		.verdict_s1     (verdict_s1)
	);

	wcv_frame_div #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_frame_div (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.verdict_vld_s1 (verdict_vld_s1),
		.verdict_s1     (verdict_s1),
		.out_valid      (out_valid),
		.valid_res      (valid_res),
		.frame_count    (frame_count)
	);

	a_invalid_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> frame_count == 30'd0)
		else $error("invalid file reported with nonzero frame count");

endmodule

@@ rtl/core/wcv_parser.sv @@
module wcv_parser #(
	parameter int unsigned CHANNELS    = wcv_pkg::CHANNELS_DEF,
	parameter int unsigned SAMPLE_BITS = wcv_pkg::SAMPLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic              en,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic [31:0]       want_rate,
	output logic              verdict_vld_s1,
	output wcv_pkg::verdict_t verdict_s1
);

	wcv_pkg::phase_t phase_q, phase_d;
	logic [3:0]  fi_q, fi_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] ws_q, ws_d;
	logic [31:0] skip_q, skip_d;
	logic        pad_q, pad_d;
	logic        fm_q, fm_d;
	logic        fok_q, fok_d;
	logic [31:0] ds_q, ds_d;
	logic [5:0]  len_q, len_d;
	logic        failed_q, failed_d;
	logic [31:0] size;
	logic        ok;

	function automatic logic fmt_byte_ok(input logic [3:0] idx, input logic [7:0] b,
			input logic [31:0] rate);
		logic [15:0] ch;
		logic [15:0] bits;
		ch   = 16'(CHANNELS);
		bits = 16'(SAMPLE_BITS);
		case (idx)
			4'd0:                    fmt_byte_ok = (b == 8'd1);
			4'd1:                    fmt_byte_ok = (b == 8'd0);
			4'd2:                    fmt_byte_ok = (b == ch[7:0]);
			4'd3:                    fmt_byte_ok = (b == ch[15:8]);
			4'd4, 4'd5, 4'd6, 4'd7:  fmt_byte_ok = (b == rate[{idx[1:0], 3'b000} +: 8]);
			4'd14:                   fmt_byte_ok = (b == bits[7:0]);
			4'd15:                   fmt_byte_ok = (b == bits[15:8]);
			default:                 fmt_byte_ok = 1'b1;
		endcase
	endfunction

	always_comb begin
		phase_d  = phase_q;
		fi_d     = fi_q;
		tag_d    = tag_q;
		ws_d     = ws_q;
		skip_d   = skip_q;
		pad_d    = pad_q;
		fm_d     = fm_q;
		fok_d    = fok_q;
		ds_d     = ds_q;
		failed_d = failed_q;
		size     = ws_q;
		len_d    = (len_q < wcv_pkg::MIN_LEN) ? len_q + 6'd1 : len_q;
		if (!failed_q) begin
			case (phase_q)
				wcv_pkg::PH_RIFF: begin
					if (fi_q < 4'd4 && data_byte != wcv_pkg::tag_byte(wcv_pkg::TAG_RIFF, fi_q[1:0]))
						failed_d = 1'b1;
					if (fi_q >= 4'd8 && data_byte != wcv_pkg::tag_byte(wcv_pkg::TAG_WAVE, fi_q[1:0]))
						failed_d = 1'b1;
					fi_d = fi_q + 4'd1;
					if (fi_q == 4'd11) begin
						fi_d    = 4'd0;
						phase_d = wcv_pkg::PH_HDR;
					end
				end
				wcv_pkg::PH_HDR: begin
					if (fi_q < 4'd4)
						tag_d = {tag_q[23:0], data_byte};
					else
						ws_d = {data_byte, ws_q[31:8]};
					fi_d = fi_q + 4'd1;
					if (fi_q == 4'd7) begin
						fi_d  = 4'd0;
						size  = ws_d;
						pad_d = size[0];
						if (tag_q == wcv_pkg::TAG_FMT) begin
							if (size < wcv_pkg::FMT_LEN) begin
								failed_d = 1'b1;
							end else begin
								skip_d  = size - wcv_pkg::FMT_LEN;
								fm_d    = 1'b1;
								phase_d = wcv_pkg::PH_FMT;
							end
						end else begin
							if (tag_q == wcv_pkg::TAG_DATA)
								ds_d = size;
							skip_d = size;
							// an empty body is even, so no pad follows it
							phase_d = (size != 32'd0) ? wcv_pkg::PH_BODY : wcv_pkg::PH_HDR;
						end
					end
				end
				wcv_pkg::PH_FMT: begin
					if (!fmt_byte_ok(fi_q, data_byte, want_rate))
						fm_d = 1'b0;
					fi_d = fi_q + 4'd1;
					if (fi_q == 4'd15) begin
						fi_d  = 4'd0;
						fok_d = fm_d;
						if (skip_q != 32'd0)
							phase_d = wcv_pkg::PH_BODY;
						else if (pad_q)
							phase_d = wcv_pkg::PH_PAD;
						else
							phase_d = wcv_pkg::PH_HDR;
					end
				end
				wcv_pkg::PH_BODY: begin
					if (skip_q != 32'd0)
						skip_d = skip_q - 32'd1;
					if (skip_d == 32'd0)
						phase_d = pad_q ? wcv_pkg::PH_PAD : wcv_pkg::PH_HDR;
				end
				wcv_pkg::PH_PAD: begin
					pad_d   = 1'b0;
					phase_d = wcv_pkg::PH_HDR;
				end
				default: failed_d = 1'b1;
			endcase
		end
		// file may close on a chunk boundary or with only the pad byte missing
		ok = !failed_d && (len_d >= wcv_pkg::MIN_LEN) &&
		     ((phase_d == wcv_pkg::PH_HDR && fi_d == 4'd0) || phase_d == wcv_pkg::PH_PAD) &&
		     fok_d && (ds_d != 32'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wcv_pkg::PH_RIFF;
			fi_q     <= '0;
			tag_q    <= '0;
			ws_q     <= '0;
			skip_q   <= '0;
			pad_q    <= 1'b0;
			fm_q     <= 1'b0;
			fok_q    <= 1'b0;
			ds_q     <= '0;
			len_q    <= '0;
			failed_q <= 1'b0;
		end else if (take) begin
			if (last_byte) begin
				phase_q  <= wcv_pkg::PH_RIFF;
				fi_q     <= '0;
				tag_q    <= '0;
				ws_q     <= '0;
				skip_q   <= '0;
				pad_q    <= 1'b0;
				fm_q     <= 1'b0;
				fok_q    <= 1'b0;
				ds_q     <= '0;
				len_q    <= '0;
				failed_q <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				fi_q     <= fi_d;
				tag_q    <= tag_d;
				ws_q     <= ws_d;
				skip_q   <= skip_d;
				pad_q    <= pad_d;
				fm_q     <= fm_d;
				fok_q    <= fok_d;
				ds_q     <= ds_d;
				len_q    <= len_d;
				failed_q <= failed_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_vld_s1 <= 1'b0;
		end else if (en) begin
			verdict_vld_s1 <= take && last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			verdict_s1.ok   <= ok;
			verdict_s1.size <= ds_d;
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		take && last_byte |=> phase_q == wcv_pkg::PH_RIFF && fi_q == 4'd0 && !failed_q &&
			len_q == 6'd0)
		else $error("parse state not cleared after last item");

	a_body_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == wcv_pkg::PH_BODY |-> skip_q != 32'd0)
		else $error("body phase with nothing left to skip");

	a_failed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q && !(take && last_byte) |=> failed_q)
		else $error("failure dropped before the file closed");

endmodule

@@ rtl/core/wcv_frame_div.sv @@
module wcv_frame_div #(
	parameter int unsigned CHANNELS    = wcv_pkg::CHANNELS_DEF,
	parameter int unsigned SAMPLE_BITS = wcv_pkg::SAMPLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              verdict_vld_s1,
	input  wcv_pkg::verdict_t verdict_s1,
	output logic              out_valid,
	output logic              valid_res,
	output logic [29:0]       frame_count
);

	localparam int unsigned FRAME   = CHANNELS * (SAMPLE_BITS / 8);
	localparam bit          FRAME_OK = (FRAME != 0);
	localparam int unsigned DIV     = FRAME_OK ? FRAME : 1;
	localparam int unsigned SHIFT   = 32 + $clog2(DIV);
	// floor(2^SHIFT / DIV) fits 33 bits; estimate is exact or one short
	localparam logic [63:0] RECIP64 = (64'd1 << SHIFT) / 64'(DIV);
	localparam logic [32:0] RECIP   = RECIP64[32:0];
	localparam logic [37:0] DIV38   = 38'(DIV);

	logic        vld_s2;
	logic        ok_s2;
	logic [31:0] x_s2;
	logic [64:0] prod_s2;

	logic [31:0] q_est;
	logic [37:0] rem_raw;
	logic        fix;
	logic [37:0] rem;
	logic [32:0] q;
	logic        ok_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s2    <= verdict_vld_s1;
			out_valid <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s2   <= verdict_s1.ok && FRAME_OK;
			x_s2    <= verdict_s1.size;
			prod_s2 <= 65'(verdict_s1.size) * 65'(RECIP);
		end
	end

	always_comb begin
		q_est   = 32'(prod_s2 >> SHIFT);
		rem_raw = 38'(x_s2) - 38'(q_est) * DIV38;
		fix     = rem_raw >= DIV38;
		rem     = fix ? rem_raw - DIV38 : rem_raw;
		q       = 33'(q_est) + 33'(fix);
		ok_fin  = ok_s2 && (rem == 38'd0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			valid_res <= ok_fin;
			if (!ok_fin)
				frame_count <= '0;
			else if (q > 33'(wcv_pkg::COUNT_MAX))
				frame_count <= wcv_pkg::COUNT_MAX;
			else
				frame_count <= q[29:0];
		end
	end

	a_valid_has_frames: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> frame_count != 30'd0)
		else $error("valid file reported with no frames");

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;

	localparam int unsigned NCH    = wcv_pkg::CHANNELS_DEF;
	localparam int unsigned NBITS  = wcv_pkg::SAMPLE_BITS_DEF;
	localparam int unsigned NFRAME = NCH * (NBITS / 8);

	localparam logic [31:0] TAG_LIST  = 32'h4C49_5354;
	localparam logic [15:0] FMT_PCM   = 16'd1;
	localparam logic [15:0] FMT_FLOAT = 16'd3;

	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_AT      = 12;
	localparam int HOLD_LEN     = 300;
	localparam int MAX_PRINTS   = 40;

	typedef struct packed {
		logic        ok;
		logic [29:0] frames;
	} wav_verdict_t;

	// Tracks the parser state of the file in flight and the verdicts still owed.
	class wav_scoreboard;
		logic [31:0]      rate;
		wcv_pkg::phase_t  ph;
		int               idx;
		logic [31:0]      tag;
		logic [31:0]      word;
		logic [32:0]      skip;
		logic             pad;
		logic             fmt_run;
		logic             fmt_good;
		logic [31:0]      dsize;
		int               seen;
		logic             broken;
		wav_verdict_t     verdicts[$];
		int               errors;
		int               checked;
		int               valid_seen;

		function new();
			rate       = wcv_pkg::WANT_RATE_RST;
			errors     = 0;
			checked    = 0;
			valid_seen = 0;
			clear_file();
		endfunction

		function void clear_file();
			ph       = wcv_pkg::PH_RIFF;
			idx      = 0;
			tag      = '0;
			word     = '0;
			skip     = '0;
			pad      = 1'b0;
			fmt_run  = 1'b0;
			fmt_good = 1'b0;
			dsize    = '0;
			seen     = 0;
			broken   = 1'b0;
		endfunction

		function void end_of_body();
			if (skip != 0) begin
				ph = wcv_pkg::PH_BODY;
			end else if (pad) begin
				ph = wcv_pkg::PH_PAD;
			end else begin
				ph = wcv_pkg::PH_HDR;
			end
		endfunction

		function logic fmt_field_ok(int i, logic [7:0] b);
			logic [15:0] ch;
			logic [15:0] bits;
			ch   = 16'(NCH);
			bits = 16'(NBITS);
			case (i)
				0: return b == FMT_PCM[7:0];
				1: return b == FMT_PCM[15:8];
				2: return b == ch[7:0];
				3: return b == ch[15:8];
				4, 5, 6, 7: return b == rate[8*(i-4) +: 8];
				14: return b == bits[7:0];
				15: return b == bits[15:8];
				default: return 1'b1;
			endcase
		endfunction

		function void parse_byte(logic [7:0] b);
			case (ph)
				wcv_pkg::PH_RIFF: begin
					if (idx < 4 && b != wcv_pkg::TAG_RIFF[31 - 8*idx -: 8])
						broken = 1'b1;
					if (idx >= 8 && b != wcv_pkg::TAG_WAVE[31 - 8*(idx-8) -: 8])
						broken = 1'b1;
					idx++;
					if (idx >= 12) begin
						idx = 0;
						ph  = wcv_pkg::PH_HDR;
					end
				end
				wcv_pkg::PH_HDR: begin
					if (idx < 4)
						tag = {tag[23:0], b};
					else
						word = {b, word[31:8]};
					idx++;
					if (idx >= 8) begin
						idx = 0;
						pad = word[0];
						if (tag == wcv_pkg::TAG_FMT) begin
							if (word < wcv_pkg::FMT_LEN) begin
								broken = 1'b1;
							end else begin
								skip    = {1'b0, word - wcv_pkg::FMT_LEN};
								fmt_run = 1'b1;
								ph      = wcv_pkg::PH_FMT;
							end
						end else begin
							if (tag == wcv_pkg::TAG_DATA)
								dsize = word;
							skip = {1'b0, word};
							end_of_body();
						end
					end
				end
				wcv_pkg::PH_FMT: begin
					if (!fmt_field_ok(idx, b))
						fmt_run = 1'b0;
					idx++;
					if (idx >= wcv_pkg::FMT_LEN) begin
						idx      = 0;
						fmt_good = fmt_run;
						end_of_body();
					end
				end
				wcv_pkg::PH_BODY: begin
					if (skip != 0)
						skip--;
					if (skip == 0)
						ph = pad ? wcv_pkg::PH_PAD : wcv_pkg::PH_HDR;
				end
				wcv_pkg::PH_PAD: begin
					pad = 1'b0;
					ph  = wcv_pkg::PH_HDR;
				end
				default: broken = 1'b1;
			endcase
		endfunction

		function void note_byte(logic [7:0] b, logic lst);
			wav_verdict_t v;
			logic [31:0]  frames;
			if (seen < wcv_pkg::MIN_LEN)
				seen++;
			if (!broken)
				parse_byte(b);
			if (lst) begin
				// a file may stop at a chunk boundary or just short of a pad byte
				v.ok = !broken && seen >= wcv_pkg::MIN_LEN &&
					((ph == wcv_pkg::PH_HDR && idx == 0) || ph == wcv_pkg::PH_PAD) &&
					fmt_good && dsize != 0 && NFRAME != 0 && (dsize % NFRAME) == 0;
				v.frames = '0;
				if (v.ok) begin
					frames   = dsize / NFRAME;
					v.frames = (frames > wcv_pkg::COUNT_MAX) ? wcv_pkg::COUNT_MAX :
						frames[29:0];
				end
				verdicts.insert(verdicts.size(), v);
				clear_file();
			end
		endfunction

		function int pending();
			return verdicts.size();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTS)
				$display("MISMATCH: %s", msg);
		endtask

		task check_result(logic ok, logic [29:0] frames);
			wav_verdict_t v;
			checked++;
			if (verdicts.size() == 0) begin
				report($sformatf("verdict %0d arrived with none outstanding", checked));
				return;
			end
			v = verdicts.pop_front();
			if (ok !== v.ok)
				report($sformatf("verdict %0d: valid_res %b, predicted %b", checked, ok, v.ok));
			if (frames !== v.frames)
				report($sformatf("verdict %0d: frame_count %0d, predicted %0d",
					checked, frames, v.frames));
			if (v.ok)
				valid_seen++;
		endtask
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        valid_res;
	logic [29:0] frame_count;
	logic        cfg_we    = 1'b0;
	logic [31:0] cfg_wdata = '0;

	wav_scoreboard board;
	logic [7:0]    file_q[$];
	int            bytes_sent = 0;
	int            files_sent = 0;
	int            rcv_count  = 0;
	int            hold_left  = 0;
	bit            hold_done  = 1'b0;

	wav_chunk_validator #(
		.CHANNELS    (NCH),
		.SAMPLE_BITS (NBITS)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.valid_res   (valid_res),
		.frame_count (frame_count),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	always #5 clk = ~clk;

	// receiver: random stalls, one long hold-off, and a calm stretch
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				rcv_count++;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && rcv_count == HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
				out_ready <= 1'b0;
			end else if (rcv_count >= 25 && rcv_count < 35) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 14);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			board.check_result(valid_res, frame_count);

	function automatic void put8(input logic [7:0] b);
		file_q.insert(file_q.size(), b);
	endfunction

	function automatic void put16(input logic [15:0] v);
		put8(v[7:0]);
		put8(v[15:8]);
	endfunction

	function automatic void put32(input logic [31:0] v);
		put16(v[15:0]);
		put16(v[31:16]);
	endfunction

	function automatic void put_tag(input logic [31:0] t);
		for (int i = 3; i >= 0; i--)
			put8(t[8*i +: 8]);
	endfunction

	function automatic void add_body(input int unsigned n);
		repeat (n) put8(8'($urandom()));
	endfunction

	function automatic void add_hdr(input logic [31:0] t, input logic [31:0] size);
		put_tag(t);
		put32(size);
	endfunction

	function automatic void add_chunk(input logic [31:0] t, input logic [31:0] size,
			input bit with_pad);
		add_hdr(t, size);
		add_body(size);
		if (with_pad && size[0])
			add_body(1);
	endfunction

	function automatic void add_fmt(input logic [31:0] size, input logic [15:0] code,
			input logic [15:0] ch, input logic [31:0] rate, input logic [15:0] bits,
			input bit with_pad);
		add_hdr(wcv_pkg::TAG_FMT, size);
		if (size < wcv_pkg::FMT_LEN) begin
			add_body(size);
		end else begin
			put16(code);
			put16(ch);
			put32(rate);
			put32($urandom());
			put16(16'($urandom()));
			put16(bits);
			add_body(size - wcv_pkg::FMT_LEN);
		end
		if (with_pad && size[0])
			add_body(1);
	endfunction

	function automatic void good_fmt();
		add_fmt(wcv_pkg::FMT_LEN, FMT_PCM, 16'(NCH), board.rate, 16'(NBITS), 1'b1);
	endfunction

	function automatic void start_riff();
		file_q.delete();
		put_tag(wcv_pkg::TAG_RIFF);
		put32($urandom());
		put_tag(wcv_pkg::TAG_WAVE);
	endfunction

	function automatic void trim_to(input int n);
		while (file_q.size() > n)
			void'(file_q.pop_back());
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic lst);
		while ((bytes_sent < 400 || bytes_sent >= 900) && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= lst;
		do @(posedge clk); while (!in_ready);
		board.note_byte(b, lst);
		bytes_sent++;
	endtask

	task automatic send_file();
		for (int i = 0; i < file_q.size(); i++)
			send_byte(file_q[i], i == file_q.size() - 1);
		files_sent++;
	endtask

	// only between files, with every verdict back and the pipeline empty
	task automatic set_rate(input logic [31:0] r);
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we     <= 1'b0;
		board.rate = r;
	endtask

	task automatic directed_files();
		start_riff(); good_fmt(); add_chunk(wcv_pkg::TAG_DATA, 4, 1'b1); send_file();
		start_riff(); add_chunk(TAG_LIST, 3, 1'b1);
		add_fmt(18, FMT_PCM, 16'(NCH), board.rate, 16'(NBITS), 1'b1);
		add_chunk(wcv_pkg::TAG_DATA, 8, 1'b1); send_file();
		start_riff(); add_fmt(17, FMT_PCM, 16'(NCH), board.rate, 16'(NBITS), 1'b1);
		add_chunk(wcv_pkg::TAG_DATA, 12, 1'b1); send_file();
		// file ends where only a pad byte is missing
		start_riff(); good_fmt(); add_chunk(wcv_pkg::TAG_DATA, 8, 1'b1);
		add_chunk(TAG_LIST, 5, 1'b0); send_file();
		// fmt too short to hold the fixed fields
		start_riff(); add_fmt(15, FMT_PCM, 16'(NCH), board.rate, 16'(NBITS), 1'b1);
		add_chunk(wcv_pkg::TAG_DATA, 4, 1'b1); send_file();
		// stops inside the fixed fmt fields, inside a data body, inside a header
		start_riff(); add_chunk(TAG_LIST, 20, 1'b1); add_hdr(wcv_pkg::TAG_FMT, wcv_pkg::FMT_LEN);
		add_body(10); send_file();
		start_riff(); good_fmt(); add_hdr(wcv_pkg::TAG_DATA, 12); add_body(8); send_file();
		start_riff(); good_fmt(); add_chunk(wcv_pkg::TAG_DATA, 4, 1'b1); add_hdr(TAG_LIST, 4);
		trim_to(file_q.size() - 3); send_file();
		// broken RIFF and WAVE marks; the rest of the file must be ignored
		start_riff(); file_q[0] = 8'h58; good_fmt();
		add_chunk(wcv_pkg::TAG_DATA, 4, 1'b1); send_file();
		start_riff(); file_q[11] = 8'h44; good_fmt();
		add_chunk(wcv_pkg::TAG_DATA, 4, 1'b1); send_file();
		// one wrong field each: format code, channels, rate, bits
		for (int k = 0; k < 4; k++) begin
			start_riff();
			add_fmt(wcv_pkg::FMT_LEN, k == 0 ? FMT_FLOAT : FMT_PCM,
				k == 1 ? 16'(NCH + 1) : 16'(NCH),
				k == 2 ? board.rate ^ 32'h8000_0001 : board.rate,
				k == 3 ? 16'(NBITS + 8) : 16'(NBITS), 1'b1);
			add_chunk(wcv_pkg::TAG_DATA, 8, 1'b1);
			send_file();
		end
		// the last fmt and the last data chunk decide
		start_riff();
		add_fmt(wcv_pkg::FMT_LEN, FMT_FLOAT, 16'(NCH), board.rate, 16'(NBITS), 1'b1);
		good_fmt(); add_chunk(wcv_pkg::TAG_DATA, 8, 1'b1); send_file();
		start_riff(); good_fmt();
		add_fmt(wcv_pkg::FMT_LEN, FMT_FLOAT, 16'(NCH), board.rate, 16'(NBITS), 1'b1);
		add_chunk(wcv_pkg::TAG_DATA, 8, 1'b1); send_file();
		start_riff(); good_fmt(); add_chunk(wcv_pkg::TAG_DATA, 6, 1'b1);
		add_chunk(wcv_pkg::TAG_DATA, 16, 1'b1); send_file();
		start_riff(); good_fmt(); add_chunk(wcv_pkg::TAG_DATA, 16, 1'b1);
		add_chunk(wcv_pkg::TAG_DATA, 6, 1'b1); send_file();
		// empty and ragged data, missing fmt, missing data
		start_riff(); good_fmt(); add_chunk(wcv_pkg::TAG_DATA, 0, 1'b1); send_file();
		start_riff(); good_fmt(); add_chunk(wcv_pkg::TAG_DATA, 5, 1'b1); send_file();
		start_riff(); add_chunk(wcv_pkg::TAG_DATA, 24, 1'b1); send_file();
		start_riff(); good_fmt(); add_chunk(TAG_LIST, 12, 1'b1); send_file();
		// too short
		file_q.delete(); add_body(1); send_file();
		start_riff(); add_body(8); send_file();
		// chunk claiming the whole size range, cut off; then a file of 0xFF bytes only
		start_riff(); good_fmt(); add_chunk(wcv_pkg::TAG_DATA, 4, 1'b1);
		add_hdr(TAG_LIST, 32'hFFFF_FFFF); add_body(4); send_file();
		file_q.delete(); repeat (50) put8(8'hFF); send_file();
	endtask

	// mostly well-formed files with random content; some cut short, some noise
	task automatic random_file();
		int          roll;
		logic [31:0] fsz;
		logic [31:0] dsz;
		logic [15:0] code;
		logic [15:0] ch;
		logic [15:0] bits;
		logic [31:0] r;
		roll = $urandom_range(99);
		if (roll < 12) begin
			file_q.delete();
			if ($urandom_range(2) == 0)
				start_riff();
			add_body($urandom_range(60, 1));
		end else begin
			start_riff();
			if ($urandom_range(3) == 0)
				add_chunk(TAG_LIST, $urandom_range(9), 1'b1);
			if ($urandom_range(9) == 0)
				add_chunk($urandom(), $urandom_range(5), 1'b1);
			code = FMT_PCM;
			ch   = 16'(NCH);
			bits = 16'(NBITS);
			r    = board.rate;
			case ($urandom_range(11))
				0: code = FMT_FLOAT;
				1: ch = 16'($urandom());
				2: r = $urandom();
				3: bits = 16'($urandom_range(32));
				default: ;
			endcase
			fsz = ($urandom_range(3) == 0) ? $urandom_range(21, 12) : wcv_pkg::FMT_LEN;
			add_fmt(fsz, code, ch, r, bits, 1'b1);
			if ($urandom_range(4) == 0)
				add_chunk(TAG_LIST, $urandom_range(7), 1'b1);
			dsz = ($urandom_range(7) == 0) ? $urandom_range(20) : NFRAME * $urandom_range(6, 1);
			add_chunk(wcv_pkg::TAG_DATA, dsz, 1'b1);
			if ($urandom_range(7) == 0)
				add_chunk(TAG_LIST, 2 * $urandom_range(3) + 1, 1'b0);
			if (roll < 24) begin
				trim_to($urandom_range(file_q.size() - 1, 1));
			end else if (roll < 28) begin
				add_hdr($urandom(), $urandom());
				add_body($urandom_range(4));
			end
		end
		send_file();
	endtask

	initial begin
		logic [31:0] rate_plan [5];
		int          start_bytes;
		board = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_files();
		rate_plan = '{32'd44100, 32'd0, 32'hFFFF_FFFF, $urandom(), wcv_pkg::WANT_RATE_RST};
		foreach (rate_plan[p]) begin
			set_rate(rate_plan[p]);
			start_bytes = bytes_sent;
			while (bytes_sent - start_bytes < 40)
				random_file();
		end
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d files in %0d bytes over %0d sample rates; %0d verdicts, %0d valid",
			files_sent, bytes_sent, $size(rate_plan), board.checked, board.valid_seen);
		$display("output held off for %0d cycles once with input still offered", HOLD_LEN);
		if (board.errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin
		#3000000;
		$display("timeout: %0d verdicts still outstanding", board.pending());
		$display("tb_top failed");
		$finish;
	end

endmodule
